@@ hw/rtl/stz_pkg.sv @@
// ----------------------------------------------------------------------------
// stz_pkg
// Shared types and constants of the size-to-decimal-text converter.
// ----------------------------------------------------------------------------
package stz_pkg;

	localparam int VALUE_W    = 64;                      // byte count width
	localparam int NUM_DIGITS = 20;                      // 2^64 < 10^20
	localparam int BCD_W      = 4;
	localparam int CHAR_W     = 8;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);
	localparam int SCALE_SH   = 10;                      // divide by 1024

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;     // '0'
	localparam logic [CHAR_W-1:0] CHAR_K    = 8'h4B;
	localparam logic [CHAR_W-1:0] CHAR_M    = 8'h4D;
	localparam logic [CHAR_W-1:0] CHAR_G    = 8'h47;

	typedef enum logic [1:0] {
		SCAL_NONE = 2'd0,
		SCAL_KILO = 2'd1,
		SCAL_MEGA = 2'd2,
		SCAL_GIGA = 2'd3
	} scal_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT,
		ST_UNIT
	} state_t;

	// control word broadcast to every digit cell
	typedef struct packed {
		logic clear;   // zero the digit
		logic conv;    // add-3 correction and shift one bit in
		logic move;    // take the digit of the lower neighbor
	} cell_ctl_t;

	function automatic logic [CHAR_W-1:0] unit_letter(input scal_t s);
		logic [CHAR_W-1:0] c;
		unique case (s)
			SCAL_KILO: c = CHAR_K;
			SCAL_MEGA: c = CHAR_M;
			SCAL_GIGA: c = CHAR_G;
			default:   c = CHAR_ZERO;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/stz_bcd_cell.sv @@
// ----------------------------------------------------------------------------
// stz_bcd_cell
// One BCD digit of the shift-and-add-3 chain; also shifts digits upward.
// ----------------------------------------------------------------------------
module stz_bcd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stz_pkg::cell_ctl_t            ctl,
	input  logic                          bit_in,
	input  logic [stz_pkg::BCD_W-1:0]     digit_in,
	output logic                          carry_out,
	output logic [stz_pkg::BCD_W-1:0]     digit
);
	import stz_pkg::*;

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		adj = (digit_q >= BCD_W'(5)) ? digit_q + BCD_W'(3) : digit_q;
	end

	assign carry_out = adj[BCD_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				digit_q <= '0;
			end else if (ctl.conv) begin
				digit_q <= {adj[BCD_W-2:0], bit_in};
			end else if (ctl.move) begin
				digit_q <= digit_in;
			end
		end
	end

endmodule

@@ hw/rtl/stz_bcd_chain.sv @@
// ----------------------------------------------------------------------------
// stz_bcd_chain
// Row of BCD digit cells; least significant digit at cell 0.
// ----------------------------------------------------------------------------
module stz_bcd_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stz_pkg::cell_ctl_t            ctl,
	input  logic                          bit_in,
	output logic [stz_pkg::BCD_W-1:0]     top_digit,
	output logic                          spill
);
	import stz_pkg::*;

	logic [NUM_DIGITS:0]   carry;
	logic [BCD_W-1:0]      digits [NUM_DIGITS+1];

	assign carry[0]  = bit_in;
	assign digits[0] = '0;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		stz_bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.bit_in    (carry[i]),
			.digit_in  (digits[i]),
			.carry_out (carry[i+1]),
			.digit     (digits[i+1])
		);
	end

	assign top_digit = digits[NUM_DIGITS];
	assign spill     = carry[NUM_DIGITS];

endmodule

@@ hw/rtl/size_to_decimal_text.sv @@
// ----------------------------------------------------------------------------
// size_to_decimal_text
// Byte count to ASCII decimal text, optional 1024-based scaling with K/M/G.
// ----------------------------------------------------------------------------
// Operation: after accept, the count is converted bit-serially to BCD through
//   the digit cell row, leading zeros are dropped (up to 19), then the digits
//   are sent most significant first, one character per accepted word, then the K/M/G letter if scaled.
// Throughput: one count at a time; a new count is taken only once the last
//   character of the previous one has been accepted.
// Reset (arst_n low, asynchronous): idle, human_mode cleared, no word pending.
// ----------------------------------------------------------------------------
module size_to_decimal_text (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: human_mode
	input  logic                              human_mode_we,
	input  logic                              human_mode_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [stz_pkg::VALUE_W-1:0]       s_tdata,   // [63:0] size_value
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [stz_pkg::CHAR_W-1:0]        m_tdata,   // [7:0] char_code
	output logic                              m_tlast    // last_char
);
	import stz_pkg::*;

	state_t                 state_q, state_d;
	logic                   human_mode_q;
	logic [VALUE_W-1:0]     value_q;      // scaled count, shifted out MSB first
	scal_t                  scal_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [REM_W-1:0]       rem_q;        // digits still in the row to show

	cell_ctl_t              ctl;
	logic [BCD_W-1:0]       top_digit;
	logic                   spill;

	logic                   in_acc, out_acc;
	logic                   rem_load, rem_dec;
	scal_t                  scal_in;
	logic [VALUE_W-1:0]     scaled_in;

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = m_tvalid & m_tready;

	// Scale on entry: the number of 1024 divisions is set by the highest
	// threshold the count reaches, capped at three.
	always_comb begin
		scal_in = SCAL_NONE;
		if (human_mode_q) begin
			priority if (s_tdata[VALUE_W-1:3*SCALE_SH] != '0) begin
				scal_in = SCAL_GIGA;
			end else if (s_tdata[VALUE_W-1:2*SCALE_SH] != '0) begin
				scal_in = SCAL_MEGA;
			end else if (s_tdata[VALUE_W-1:SCALE_SH] != '0) begin
				scal_in = SCAL_KILO;
			end else begin
				scal_in = SCAL_NONE;
			end
		end
		unique case (scal_in)
			SCAL_KILO: scaled_in = s_tdata >> SCALE_SH;
			SCAL_MEGA: scaled_in = s_tdata >> (2*SCALE_SH);
			SCAL_GIGA: scaled_in = s_tdata >> (3*SCALE_SH);
			default:   scaled_in = s_tdata;
		endcase
	end

	// Digit row: double-dabble while converting, then a shift line that
	// brings the next most significant digit to the top.
	stz_bcd_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.bit_in    (value_q[VALUE_W-1]),
		.top_digit (top_digit),
		.spill     (spill)
	);

	// Sequencer: next state, cell control and output word.
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		m_tdata   = CHAR_ZERO;
		m_tlast   = 1'b0;
		rem_load  = 1'b0;
		rem_dec   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.clear = 1'b1;
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				ctl.conv = 1'b1;
				if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
					rem_load = 1'b1;
					state_d  = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (top_digit == '0 && rem_q > REM_W'(1)) begin
					ctl.move = 1'b1;
					rem_dec  = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				m_tdata  = CHAR_ZERO + CHAR_W'(top_digit);
				m_tlast  = (rem_q == REM_W'(1)) && (scal_q == SCAL_NONE);
				if (m_tready) begin
					if (rem_q > REM_W'(1)) begin
						ctl.move = 1'b1;
						rem_dec  = 1'b1;
					end else if (scal_q != SCAL_NONE) begin
						state_d = ST_UNIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_UNIT: begin
				m_tvalid = 1'b1;
				m_tdata  = unit_letter(scal_q);
				m_tlast  = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			human_mode_q <= 1'b0;
			bit_cnt_q    <= '0;
			rem_q        <= '0;
		end else begin
			state_q <= state_d;
			if (human_mode_we) begin
				human_mode_q <= human_mode_wdata;
			end
			if (in_acc) begin
				bit_cnt_q <= '0;
			end else if (ctl.conv) begin
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			end
			if (rem_load) begin
				rem_q <= REM_W'(NUM_DIGITS);
			end else if (rem_dec) begin
				rem_q <= rem_q - REM_W'(1);
			end
		end
	end

	// Payload: hold the scaled count and its unit, advance one bit per cycle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			value_q <= scaled_in;
			scal_q  <= scal_in;
		end else if (ctl.conv) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
		end
	end

	// The row is sized so the top digit never overflows.
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.conv |-> !spill)
		else $error("BCD row overflow during conversion");

	// One count at a time: no new count while a word is offered.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while output word pending");

	// The digit counter never runs empty while digits are shown.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_SKIP) |-> (rem_q != '0))
		else $error("digit counter empty while emitting");

	// After the last word of a count, the block is idle again.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (state_q == ST_IDLE))
		else $error("not idle after last character");

	// An accepted count always enters conversion.
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_CONV && bit_cnt_q == '0))
		else $error("accepted count did not start conversion");

endmodule

@@ test/size_to_decimal_text_test.sv @@
// ----------------------------------------------------------------------------
// size_to_decimal_text_test
// Drives byte counts into the converter with bursty input and a stalling
// output, rebuilds the expected ASCII text of every accepted count with and
// without 1024-based scaling, and checks each output word in order.
// ----------------------------------------------------------------------------
module size_to_decimal_text_test;
	timeunit 1ns;
	timeprecision 1ps;

	import stz_pkg::*;

	localparam logic [VALUE_W-1:0] SCALE_STEP = 64'd1 << SCALE_SH;  // 1024
	localparam int IDLE_LIMIT = 5000;  // cycles with no word moving on either side
	localparam int LONG_HOLD  = 400;   // receiver hold-off that backs the block up
	localparam int DRAIN_WAIT = 150;   // settle time after the last expected word

	// directed counts written as plain digits
	localparam logic [VALUE_W-1:0] PLAIN_CASES [10] = '{
		64'd0, 64'd1, 64'd9, 64'd10, 64'd1023, 64'd1024,
		64'd9999999999999999999, 64'd10000000000000000000,
		64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF
	};

	// directed counts for scaled text: unit edges, and values still large
	// after three divisions (written in full with G)
	localparam logic [VALUE_W-1:0] SCALED_CASES [12] = '{
		64'd0, 64'd5, 64'd1023, 64'd1024, 64'd1025, 64'd2047,
		64'd1048575, 64'd1048576, 64'd1073741823, 64'd1073741824,
		64'd1099511627776, 64'hFFFF_FFFF_FFFF_FFFF
	};

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	typedef enum int {
		RX_STEADY,   // always ready
		RX_RANDOM,   // ready about half the time
		RX_SPARSE    // ready about one cycle in four
	} rx_mode_t;

	// ------------------------------------------------------------------------
	// Scoreboard: expands each accepted count into the characters it must
	// produce and checks output words against them in order.
	// ------------------------------------------------------------------------
	class text_scoreboard;
		bit         human_mode;
		text_char_t expected_chars[$];
		int         errors;

		// work out the text of one accepted count and queue it
		function void note_size(logic [VALUE_W-1:0] size);
			logic [VALUE_W-1:0] v;
			scal_t              scale;
			logic [CHAR_W-1:0]  digits[$];
			text_char_t         ch;
			v = size;
			scale = SCAL_NONE;
			if (human_mode) begin
				while (v >= SCALE_STEP && scale != SCAL_GIGA) begin
					v = v >> SCALE_SH;
					scale = scal_t'(scale + 1);
				end
			end
			// least significant digit first, so build the text from the front
			do begin
				digits.push_front(CHAR_ZERO + CHAR_W'(v % 10));
				v = v / 10;
			end while (v != 0);
			foreach (digits[i]) begin
				ch.code = digits[i];
				ch.last = (i == digits.size() - 1) && (scale == SCAL_NONE);
				expected_chars.push_back(ch);
			end
			if (scale != SCAL_NONE) begin
				case (scale)
					SCAL_KILO: ch.code = CHAR_K;
					SCAL_MEGA: ch.code = CHAR_M;
					default:   ch.code = CHAR_G;
				endcase
				ch.last = 1'b1;
				expected_chars.push_back(ch);
			end
		endfunction

		// compare one output word with the oldest expected character
		function void check_char(logic [CHAR_W-1:0] code, logic last);
			text_char_t ch;
			if (expected_chars.size() == 0) begin
				$error("unexpected word: char_code %h, last_char %b", code, last);
				errors++;
			end else begin
				ch = expected_chars.pop_front();
				if (code !== ch.code) begin
					$error("char_code: expected %h, got %h", ch.code, code);
					errors++;
				end
				if (last !== ch.last) begin
					$error("last_char: expected %b, got %b", ch.last, last);
					errors++;
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block under test
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               human_mode_we = 1'b0;
	logic               human_mode_wdata = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [CHAR_W-1:0]  m_tdata;
	logic               m_tlast;

	text_scoreboard sb;

	int stall_requests = 0;  // raised by the stimulus, served by the receiver
	int stalls_served = 0;
	int hold_left = 0;
	int mode_left = 0;
	rx_mode_t ready_mode = RX_STEADY;
	int idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	size_to_decimal_text DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.human_mode_we    (human_mode_we),
		.human_mode_wdata (human_mode_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast)
	);

	// ------------------------------------------------------------------------
	// Receiver: check every accepted word, then pick the next ready level.
	// A pending hold-off request takes precedence over the stall pattern.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_char(m_tdata, m_tlast);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_requests != stalls_served) begin
				stalls_served++;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				// switch pattern now and then so steady stretches occur too
				if (mode_left == 0) begin
					ready_mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (ready_mode)
					RX_STEADY: m_tready <= 1'b1;
					RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
					default:   m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if no word moves for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("size_to_decimal_text_test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks. Each is entered right after a rising edge.
	// ------------------------------------------------------------------------

	// offer one count and hold it until the block takes it
	task automatic send_size(logic [VALUE_W-1:0] v);
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_size(v);
	endtask

	// drop valid for a gap
	task automatic pause_sender(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop sending and wait until all expected text has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write human_mode while the block is idle
	task automatic write_human_mode(bit on);
		wait_drained();
		human_mode_we <= 1'b1;
		human_mode_wdata <= on;
		@(posedge clk);
		human_mode_we <= 1'b0;
		sb.human_mode = on;
	endtask

	// random count: spread over all lengths, near scaling and decade edges,
	// or simply all 64 bits random
	function automatic logic [VALUE_W-1:0] random_size();
		logic [VALUE_W-1:0] v;
		int pick;
		int width;
		int shift;
		int nudge;
		pick = $urandom_range(0, 9);
		v = {$urandom, $urandom};
		if (pick <= 3) begin
			width = $urandom_range(0, 64);
			if (width < 64)
				v = v & ((64'd1 << width) - 1);
		end else if (pick <= 5) begin
			shift = 10 * $urandom_range(1, 5);
			v = VALUE_W'($urandom_range(1, 1023)) << shift;
			nudge = $urandom_range(0, 2);
			if (nudge == 0)
				v = v - 1;
			else if (nudge == 2)
				v = v + 1;
		end else if (pick == 6) begin
			v = 64'd1;
			repeat ($urandom_range(0, 19)) v = v * 10;
			if ($urandom_range(0, 1))
				v = v - 1;
		end
		return v;
	endfunction

	// random bursts with random gaps; optionally back the block up once
	task automatic run_random_items(int total, bit with_pressure);
		int sent;
		int burst;
		bit squeezed;
		sent = 0;
		squeezed = 1'b0;
		while (sent < total) begin
			if (with_pressure && !squeezed && sent >= total / 2) begin
				// receiver holds off while the sender keeps offering counts
				stall_requests <= stall_requests + 1;
				repeat (12) send_size(random_size());
				sent += 12;
				squeezed = 1'b1;
			end
			burst = $urandom_range(1, 10);
			repeat (burst) send_size(random_size());
			sent += burst;
			// sometimes run straight into the next burst
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 90));
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		sb = new;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plain digits, then scaled text
		write_human_mode(1'b0);
		foreach (PLAIN_CASES[i])
			send_size(PLAIN_CASES[i]);
		write_human_mode(1'b1);
		foreach (SCALED_CASES[i]) begin
			send_size(SCALED_CASES[i]);
			if (i % 3 == 2)
				pause_sender($urandom_range(1, 40));
		end

		// random phases, alternating the mode
		for (int phase = 0; phase < 4; phase++) begin
			write_human_mode(1'(phase % 2));
			run_random_items(100, phase == 1);
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.expected_chars.size() != 0) begin
			$error("%0d expected characters never arrived", sb.expected_chars.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("size_to_decimal_text_test passed");
		else
			$display("size_to_decimal_text_test failed");
		$finish;
	end

endmodule
